// ===== rtl/rtc_pkg.sv =====
// Shared types and constants of the RSA text codec: register indexes, operation
// codes of the multiply-reduce unit, state types and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

  localparam int VAL_W            = 10;  // residues and ciphertext values
  localparam int MOD_W            = 11;  // modulus after mapping zero to 1024
  localparam int SUM_W            = 12;  // 2*acc + addend, below 3 * 1024
  localparam int CHAR_W           = 8;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 10;
  localparam int EXP_REG_W        = 10;
  localparam int DIGITS_PER_VALUE = 3;

  localparam logic [CHAR_W-1:0]    CH_ZERO      = 8'd48;
  localparam logic [CHAR_W-1:0]    CH_NINE      = 8'd57;
  localparam logic [VAL_W-1:0]     MODULUS_RST  = 10'd253;
  localparam logic [EXP_REG_W-1:0] ENC_EXP_RST  = 10'd7;
  localparam logic [EXP_REG_W-1:0] DEC_EXP_RST  = 10'd63;
  localparam logic [MOD_W-1:0]     MOD_ZERO_SUB = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 4'd0,
    CFG_MODULUS = 4'd1,
    CFG_ENC_EXP = 4'd2,
    CFG_DEC_EXP = 4'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_t;

  typedef enum logic {
    MM_REDUCE = 1'b0,
    MM_MULT   = 1'b1
  } mm_op_t;

  typedef struct packed {
    logic             start;
    mm_op_t           op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mm_req_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_RED,
    EX_SCAN,
    EX_NEXT,
    EX_SQ,
    EX_MUL
  } ex_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_EMIT_HI,
    ST_EMIT_MID,
    ST_EMIT_LO,
    ST_EMIT_BYTE,
    ST_EMIT_BAD
  } ctl_state_t;

endpackage

`default_nettype wire

// ===== rtl/rtc_modmul.sv =====
// Bit-serial modular multiply / reduce unit: one multiplier bit per cycle,
// shift-add with up to two conditional subtractions of the modulus.
// Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtc_modmul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rtc_pkg::mm_req_t           req,
  input  logic [rtc_pkg::MOD_W-1:0]  mm,
  output logic                       done,
  output logic [rtc_pkg::VAL_W-1:0]  res
);

  localparam int                CNT_W    = $clog2(rtc_pkg::VAL_W);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(rtc_pkg::VAL_W - 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  rtc_pkg::mm_op_t             op_r, op_nxt;
  logic [rtc_pkg::VAL_W-1:0]   a_r, a_nxt;
  logic [rtc_pkg::VAL_W-1:0]   b_r, b_nxt;
  logic [rtc_pkg::VAL_W-1:0]   acc_r, acc_nxt;

  logic [rtc_pkg::SUM_W-1:0]   addend;
  logic [rtc_pkg::SUM_W-1:0]   sum;
  logic [rtc_pkg::SUM_W-1:0]   m1;
  logic [rtc_pkg::SUM_W-1:0]   m2;
  logic [rtc_pkg::SUM_W-1:0]   step;

  // In reduce mode the operand bits are shifted in, so 2*acc + bit < 2m.
  // In multiply mode a, acc < m, so 2*acc + a < 3m.
  always_comb begin
    case (op_r)
      rtc_pkg::MM_MULT: addend = b_r[rtc_pkg::VAL_W-1] ? rtc_pkg::SUM_W'(a_r) : '0;
      default:          addend = rtc_pkg::SUM_W'(b_r[rtc_pkg::VAL_W-1]);
    endcase
    sum = rtc_pkg::SUM_W'({acc_r, 1'b0}) + addend;
    m1  = rtc_pkg::SUM_W'(mm);
    m2  = {mm, 1'b0};
    if (sum >= m2) begin
      step = sum - m2;
    end else if (sum >= m1) begin
      step = sum - m1;
    end else begin
      step = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = req.op;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = step[rtc_pkg::VAL_W-1:0];
      b_nxt   = {b_r[rtc_pkg::VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

`default_nettype wire

// ===== rtl/rtc_expo.sv =====
// Left-to-right square-and-multiply sequencer around the shared multiply-reduce
// unit. Exponents below two pass the base through unreduced.
// Depends on rtc_pkg and rtc_modmul.
`timescale 1ns / 1ps
`default_nettype none

module rtc_expo #(
  parameter int EXP_W = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rtc_pkg::VAL_W-1:0]  x,
  input  logic [EXP_W-1:0]           e,
  input  logic [rtc_pkg::MOD_W-1:0]  mm,
  output logic                       done,
  output logic [rtc_pkg::VAL_W-1:0]  res
);

  localparam int BCNT_W = $clog2(EXP_W + 1);

  rtc_pkg::ex_state_t          state_r, state_nxt;
  logic [EXP_W-1:0]            e_sh_r, e_sh_nxt;
  logic [BCNT_W-1:0]           bcnt_r, bcnt_nxt;
  logic                        bit_r, bit_nxt;
  logic [rtc_pkg::VAL_W-1:0]   xr_r, xr_nxt;
  logic                        done_r, done_nxt;
  logic [rtc_pkg::VAL_W-1:0]   res_r, res_nxt;

  rtc_pkg::mm_req_t            mm_req;
  logic                        mm_done;
  logic [rtc_pkg::VAL_W-1:0]   mm_res;
  logic                        e_small;

  assign e_small = (e < EXP_W'(2));

  rtc_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .mm    (mm),
    .done  (mm_done),
    .res   (mm_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtc_pkg::EX_IDLE: begin
        if (start && !e_small) state_nxt = rtc_pkg::EX_RED;
      end
      rtc_pkg::EX_RED: begin
        if (mm_done) state_nxt = rtc_pkg::EX_SCAN;
      end
      rtc_pkg::EX_SCAN: begin
        if (e_sh_r[EXP_W-1]) state_nxt = rtc_pkg::EX_NEXT;
      end
      rtc_pkg::EX_NEXT: begin
        state_nxt = (bcnt_r == '0) ? rtc_pkg::EX_IDLE : rtc_pkg::EX_SQ;
      end
      rtc_pkg::EX_SQ: begin
        if (mm_done) state_nxt = bit_r ? rtc_pkg::EX_MUL : rtc_pkg::EX_NEXT;
      end
      rtc_pkg::EX_MUL: begin
        if (mm_done) state_nxt = rtc_pkg::EX_NEXT;
      end
      default: state_nxt = rtc_pkg::EX_IDLE;
    endcase
  end

  always_comb begin
    mm_req.start = 1'b0;
    mm_req.op    = rtc_pkg::MM_REDUCE;
    mm_req.a     = '0;
    mm_req.b     = '0;
    e_sh_nxt     = e_sh_r;
    bcnt_nxt     = bcnt_r;
    bit_nxt      = bit_r;
    xr_nxt       = xr_r;
    done_nxt     = 1'b0;
    res_nxt      = res_r;
    unique case (state_r)
      rtc_pkg::EX_IDLE: begin
        if (start) begin
          e_sh_nxt = e;
          bcnt_nxt = BCNT_W'(EXP_W);
          if (e_small) begin
            done_nxt = 1'b1;
            res_nxt  = x;
          end else begin
            mm_req.start = 1'b1;
            mm_req.b     = x;
          end
        end
      end
      rtc_pkg::EX_RED: begin
        if (mm_done) xr_nxt = mm_res;
      end
      rtc_pkg::EX_SCAN: begin
        // drop leading zeros; the leading one is consumed here too
        e_sh_nxt = {e_sh_r[EXP_W-2:0], 1'b0};
        bcnt_nxt = bcnt_r - 1'b1;
      end
      rtc_pkg::EX_NEXT: begin
        if (bcnt_r == '0) begin
          done_nxt = 1'b1;
          res_nxt  = mm_res;
        end else begin
          mm_req.start = 1'b1;
          mm_req.op    = rtc_pkg::MM_MULT;
          mm_req.a     = mm_res;
          mm_req.b     = mm_res;
          bit_nxt      = e_sh_r[EXP_W-1];
          e_sh_nxt     = {e_sh_r[EXP_W-2:0], 1'b0};
          bcnt_nxt     = bcnt_r - 1'b1;
        end
      end
      rtc_pkg::EX_SQ: begin
        if (mm_done && bit_r) begin
          mm_req.start = 1'b1;
          mm_req.op    = rtc_pkg::MM_MULT;
          mm_req.a     = mm_res;
          mm_req.b     = xr_r;
        end
      end
      rtc_pkg::EX_MUL: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtc_pkg::EX_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    e_sh_r <= e_sh_nxt;
    bcnt_r <= bcnt_nxt;
    bit_r  <= bit_nxt;
    xr_r   <= xr_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// ===== rtl/rsa_text_codec_unit.sv =====
// Top level of the RSA text codec: configuration registers, digit gathering,
// control sequencer, decimal formatting and the output register.
// Depends on rtc_pkg and rtc_expo.
`timescale 1ns / 1ps
`default_nettype none

// Textbook RSA over a character stream. Encrypt mode raises each byte to the
// encrypt exponent modulo the modulus and returns three ASCII digits, hundreds
// first, last flag on the third. Decrypt mode gathers three digit characters,
// raises the value to the decrypt exponent and returns the low byte; a
// non-digit returns a single flagged error result and drops the partial
// triple. All modular arithmetic runs on one bit-serial multiply-reduce unit.
// An exponent of 0 or 1 skips the unit and passes the value through
// unreduced. Otherwise the value is first reduced, the leading zeros of the
// exponent are scanned off, and each exponent bit after the leading one costs
// a square, plus a multiply by the reduced value when the bit is one.
// The input is not ready while an item is in work; the next item is taken
// while the last result still waits in the output register.
module rsa_text_codec_unit #(
  parameter int EXP_WIDTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rtc_pkg::CHAR_W-1:0]      in_char,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rtc_pkg::CHAR_W-1:0]      out_char,
  output logic                            out_last,
  output logic                            out_bad_input,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int EW = (EXP_WIDTH < rtc_pkg::EXP_REG_W) ? EXP_WIDTH : rtc_pkg::EXP_REG_W;

  localparam logic [15:0] RECIP_100 = 16'd41;   // x/100 = (x*41) >> 12, x < 1099
  localparam logic [14:0] RECIP_10  = 15'd205;  // x/10  = (x*205) >> 11, x < 1000
  localparam logic [3:0]  HUND_WRAP = 4'd10;

  rtc_pkg::mode_t                     mode_r;
  logic [rtc_pkg::VAL_W-1:0]          modulus_r;
  logic [rtc_pkg::EXP_REG_W-1:0]      enc_exp_r;
  logic [rtc_pkg::EXP_REG_W-1:0]      dec_exp_r;

  rtc_pkg::ctl_state_t                state_r, state_nxt;
  logic [1:0]                         digit_cnt_r, digit_cnt_nxt;
  logic [rtc_pkg::VAL_W-1:0]          partial_r, partial_nxt;
  logic [rtc_pkg::VAL_W-1:0]          c_r, c_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [rtc_pkg::CHAR_W-1:0]         out_char_r, out_char_nxt;
  logic                               out_last_r, out_last_nxt;
  logic                               out_bad_r, out_bad_nxt;

  logic                               in_xfer;
  logic                               out_free;
  logic                               is_digit;
  logic [3:0]                         in_digit;
  logic [15:0]                        p_prod;
  logic [6:0]                         p_low;
  logic [rtc_pkg::VAL_W-1:0]          p_new;
  logic [1:0]                         cnt_inc;
  logic                               third;

  logic                               pow_start;
  logic [rtc_pkg::VAL_W-1:0]          pow_x;
  logic [EW-1:0]                      pow_e;
  logic [rtc_pkg::MOD_W-1:0]          mm;
  logic                               pow_done;
  logic [rtc_pkg::VAL_W-1:0]          pow_res;

  logic [15:0]                        c_prod;
  logic [3:0]                         c_hund;
  logic [6:0]                         c_rem;
  logic [14:0]                        rem_prod;
  logic [3:0]                         dig_hi, dig_mid, dig_lo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= rtc_pkg::MODE_ENC;
      modulus_r <= rtc_pkg::MODULUS_RST;
      enc_exp_r <= rtc_pkg::ENC_EXP_RST;
      dec_exp_r <= rtc_pkg::DEC_EXP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rtc_pkg::CFG_MODE:    mode_r    <= rtc_pkg::mode_t'(cfg_data[0]);
        rtc_pkg::CFG_MODULUS: modulus_r <= cfg_data;
        rtc_pkg::CFG_ENC_EXP: enc_exp_r <= cfg_data;
        rtc_pkg::CFG_DEC_EXP: dec_exp_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = (state_r == rtc_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // digit gathering: (10*p + d) mod 1000 = 10*(p mod 100) + d for p < 1000
  always_comb begin
    is_digit = (in_char >= rtc_pkg::CH_ZERO) && (in_char <= rtc_pkg::CH_NINE);
    in_digit = 4'(in_char - rtc_pkg::CH_ZERO);
    p_prod   = 16'(partial_r) * RECIP_100;
    p_low    = 7'(partial_r - 10'(p_prod[15:12]) * 10'd100);
    p_new    = 10'(p_low) * 10'd10 + 10'(in_digit);
    cnt_inc  = digit_cnt_r + 2'd1;
    third    = (cnt_inc == 2'(rtc_pkg::DIGITS_PER_VALUE));
  end

  assign pow_start = in_xfer && ((mode_r == rtc_pkg::MODE_ENC) || (is_digit && third));
  assign pow_x     = (mode_r == rtc_pkg::MODE_ENC) ? 10'(in_char) : p_new;
  assign pow_e     = (mode_r == rtc_pkg::MODE_ENC) ? enc_exp_r[EW-1:0] : dec_exp_r[EW-1:0];
  assign mm        = (modulus_r == '0) ? rtc_pkg::MOD_ZERO_SUB : 11'(modulus_r);

  rtc_expo #(
    .EXP_W (EW)
  ) u_expo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pow_start),
    .x     (pow_x),
    .e     (pow_e),
    .mm    (mm),
    .done  (pow_done),
    .res   (pow_res)
  );

  // decimal digits of the result; the hundreds digit wraps above 999
  always_comb begin
    c_prod   = 16'(c_r) * RECIP_100;
    c_hund   = c_prod[15:12];
    dig_hi   = (c_hund == HUND_WRAP) ? 4'd0 : c_hund;
    c_rem    = 7'(c_r - 10'(c_hund) * 10'd100);
    rem_prod = 15'(c_rem) * RECIP_10;
    dig_mid  = rem_prod[14:11];
    dig_lo   = 4'(c_rem - 7'(dig_mid) * 7'd10);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      rtc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (mode_r == rtc_pkg::MODE_ENC) begin
            state_nxt = rtc_pkg::ST_POW;
          end else if (!is_digit) begin
            state_nxt = rtc_pkg::ST_EMIT_BAD;
          end else if (third) begin
            state_nxt = rtc_pkg::ST_POW;
          end
        end
      end
      rtc_pkg::ST_POW: begin
        if (pow_done) begin
          state_nxt = (mode_r == rtc_pkg::MODE_ENC) ? rtc_pkg::ST_EMIT_HI
                                                    : rtc_pkg::ST_EMIT_BYTE;
        end
      end
      rtc_pkg::ST_EMIT_HI: begin
        if (out_free) state_nxt = rtc_pkg::ST_EMIT_MID;
      end
      rtc_pkg::ST_EMIT_MID: begin
        if (out_free) state_nxt = rtc_pkg::ST_EMIT_LO;
      end
      rtc_pkg::ST_EMIT_LO,
      rtc_pkg::ST_EMIT_BYTE,
      rtc_pkg::ST_EMIT_BAD: begin
        if (out_free) state_nxt = rtc_pkg::ST_IDLE;
      end
      default: state_nxt = rtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    digit_cnt_nxt = digit_cnt_r;
    partial_nxt   = partial_r;
    c_nxt         = c_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    unique case (state_r)
      rtc_pkg::ST_IDLE: begin
        if (in_xfer && (mode_r == rtc_pkg::MODE_DEC)) begin
          if (!is_digit || third) begin
            digit_cnt_nxt = '0;
            partial_nxt   = '0;
          end else begin
            digit_cnt_nxt = cnt_inc;
            partial_nxt   = p_new;
          end
        end
      end
      rtc_pkg::ST_POW: begin
        if (pow_done) c_nxt = pow_res;
      end
      rtc_pkg::ST_EMIT_HI: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rtc_pkg::CH_ZERO + 8'(dig_hi);
          out_last_nxt  = 1'b0;
          out_bad_nxt   = 1'b0;
        end
      end
      rtc_pkg::ST_EMIT_MID: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rtc_pkg::CH_ZERO + 8'(dig_mid);
          out_last_nxt  = 1'b0;
          out_bad_nxt   = 1'b0;
        end
      end
      rtc_pkg::ST_EMIT_LO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rtc_pkg::CH_ZERO + 8'(dig_lo);
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b0;
        end
      end
      rtc_pkg::ST_EMIT_BYTE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = c_r[rtc_pkg::CHAR_W-1:0];
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b0;
        end
      end
      rtc_pkg::ST_EMIT_BAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtc_pkg::ST_IDLE;
      digit_cnt_r <= '0;
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      partial_r   <= partial_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_r        <= c_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last      = out_last_r;
  assign out_bad_input = out_bad_r;

endmodule

`default_nettype wire

// ===== rtl/rtc_checker.sv =====
// Port-level assertions for the RSA text codec, bound to the top level.
// Depends on rsa_text_codec_unit port names.
`timescale 1ns / 1ps
`default_nettype none

module rtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       out_bad_input
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last)
                                && $stable(out_bad_input))
    else $error("result changed while stalled");

  // an error result is a single zero byte that closes its item
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_last && (out_char == 8'd0))
    else $error("error result not marked last or not zero");

  // no new item while a digit triple is still being sent
  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a result group");

  // the next digit follows right after a non-final transfer
  a_group_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a result group");

endmodule

bind rsa_text_codec_unit rtc_checker u_rtc_checker (.*);

`default_nettype wire
